// ===== rtl/c2s_pkg.sv =====
// Package for the Cartesian to spherical converter: payload types,
// angle constants and the CORDIC arctangent function. No dependencies.
package c2s_pkg;

    localparam int FracBits     = 16;
    localparam int CordicStages = 18;
    localparam int AngScale     = 60;
    localparam int NumIter      = (CordicStages < 62) ? CordicStages : 62;
    localparam int CxW          = 44;
    localparam int SqW          = 66;
    localparam int RootW        = 33;
    localparam int SqrtSteps    = 33;
    localparam int SqrtSideW    = SqW + 32;
    localparam int CordicSideW  = 65;

    localparam logic signed [63:0] PiScaled = 64'sh3243F6A8885A308D;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
    } t_in_item;

    typedef struct packed {
        logic        [31:0] radius;
        logic        [17:0] polar_angle;
        logic signed [19:0] azimuth;
    } t_out_item;

    // How the azimuth is formed: plain CORDIC angle, CORDIC angle plus pi,
    // or a fixed angle chosen when x counts as zero.
    typedef enum logic [1:0] {
        PhiCordic = 2'd0,
        PhiPlusPi = 2'd1,
        PhiFixed  = 2'd2
    } t_phi_mode;

    // Quotient of two non-negative constants by restoring long division.
    function automatic logic [63:0] const_div(input logic [63:0] n,
                                              input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] atan_pow2(input int i);
        logic signed [63:0] acc;
        logic signed [63:0] term;
        logic               neg;
        acc = '0;
        neg = 1'b0;
        if (i == 0) begin
            acc = PiScaled / 4;
        end else begin
            for (int k = 1; k * i <= AngScale; k += 2) begin
                term = 64'sd0;
                term[AngScale - k * i] = 1'b1;
                term = $signed(const_div(term, 64'(k)));
                acc  = neg ? acc - term : acc + term;
                neg  = !neg;
            end
        end
        return acc;
    endfunction

    // Round a 2^-60 angle to FracBits fraction bits, halves up.
    function automatic logic signed [63:0] to_out(input logic signed [63:0] a);
        logic signed [63:0] half;
        half = 64'sd1 <<< (AngScale - FracBits - 1);
        return (a + half) >>> (AngScale - FracBits);
    endfunction

endpackage

// ===== rtl/c2s_isqrt.sv =====
// Pipelined bit-by-bit integer square root, one root bit per stage.
// Depends on c2s_pkg. Carries a sideband word along with the data.
module c2s_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [c2s_pkg::SqW-1:0]       i_val,
    input  logic [c2s_pkg::SqrtSideW-1:0] i_side,
    output logic                          o_vld,
    output logic [c2s_pkg::RootW-1:0]     o_root,
    output logic [c2s_pkg::SqrtSideW-1:0] o_side
);
    import c2s_pkg::*;

    // Stage s holds the remainder and root once its root bit is decided.
    logic [SqW-1:0]       r_rem  [SqrtSteps];
    logic [RootW-1:0]     r_root [SqrtSteps];
    logic [SqrtSideW-1:0] r_side [SqrtSteps];
    logic                 r_vld  [SqrtSteps];

    // Restoring square root: stage s decides root bit (SqrtSteps-1-s).
    for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
        localparam int B = SqrtSteps - 1 - s;
        logic [SqW-1:0]       s_rem;
        logic [RootW-1:0]     s_root;
        logic [SqrtSideW-1:0] s_side;
        logic                 s_vld;
        logic [SqW+1:0]       n_trial;
        logic [SqW-1:0]       n_rem;
        logic [RootW-1:0]     n_root;

        if (s == 0) begin : g_first
            assign s_rem  = i_val;
            assign s_root = '0;
            assign s_side = i_side;
            assign s_vld  = i_vld;
        end else begin : g_next
            assign s_rem  = r_rem[s-1];
            assign s_root = r_root[s-1];
            assign s_side = r_side[s-1];
            assign s_vld  = r_vld[s-1];
        end

        always_comb begin
            n_trial = {2'b0, s_rem} -
                      (({{(SqW+2-RootW){1'b0}}, s_root} << (B + 1)) |
                       ((SqW+2)'(1) << (2 * B)));
            if (!n_trial[SqW+1]) begin
                n_rem  = n_trial[SqW-1:0];
                n_root = s_root | (RootW'(1) << B);
            end else begin
                n_rem  = s_rem;
                n_root = s_root;
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_side[s] <= s_side;
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= s_vld;
            end
        end
    end

    assign o_vld  = r_vld[SqrtSteps-1];
    assign o_root = r_root[SqrtSteps-1];
    assign o_side = r_side[SqrtSteps-1];

endmodule

// ===== rtl/c2s_cordic.sv =====
// Pipelined vectoring CORDIC giving the angle of (a, b), a >= 0, at 2^-60.
// Depends on c2s_pkg. Normalization stage, then one micro-rotation a stage.
module c2s_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic signed [33:0]              i_a,
    input  logic signed [33:0]              i_b,
    input  logic [c2s_pkg::CordicSideW-1:0] i_side,
    output logic                            o_vld,
    output logic signed [63:0]              o_ang,
    output logic [c2s_pkg::CordicSideW-1:0] o_side
);
    import c2s_pkg::*;

    logic signed [CxW-1:0]  r_cx  [NumIter+1];
    logic signed [CxW-1:0]  r_cy  [NumIter+1];
    logic signed [63:0]     r_ang [NumIter+1];
    logic [CordicSideW-1:0] r_sd  [NumIter+1];
    logic                   r_v   [NumIter+1];

    logic [33:0] n_ma, n_mb, n_m;
    logic [5:0]  n_sh;

    always_comb begin
        n_ma = i_a[33] ? 34'(-i_a) : 34'(i_a);
        n_mb = i_b[33] ? 34'(-i_b) : 34'(i_b);
        n_m  = (n_ma > n_mb) ? n_ma : n_mb;
        n_sh = '0;
        for (int k = 0; k < 34; k++) begin
            if (n_m[k]) begin
                n_sh = 6'(39 - k);
            end
        end
    end

    // A zero vector yields a meaningless angle; the top level never uses it.
    always_ff @(posedge i_clk) begin
        r_cx[0]  <= CxW'(i_a) <<< n_sh;
        r_cy[0]  <= CxW'(i_b) <<< n_sh;
        r_ang[0] <= '0;
        r_sd[0]  <= i_side;
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
        end
    end

    for (genvar i = 0; i < NumIter; i++) begin : g_rot
        localparam logic signed [63:0] T = atan_pow2(i);
        always_ff @(posedge i_clk) begin
            if (r_cy[i] < 0) begin
                r_cx[i+1]  <= r_cx[i] - (r_cy[i] >>> i);
                r_cy[i+1]  <= r_cy[i] + (r_cx[i] >>> i);
                r_ang[i+1] <= r_ang[i] - T;
            end else begin
                r_cx[i+1]  <= r_cx[i] + (r_cy[i] >>> i);
                r_cy[i+1]  <= r_cy[i] - (r_cx[i] >>> i);
                r_ang[i+1] <= r_ang[i] + T;
            end
            r_sd[i+1] <= r_sd[i];
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    assign o_vld  = r_v[NumIter];
    assign o_ang  = r_ang[NumIter];
    assign o_side = r_sd[NumIter];

endmodule

// ===== rtl/cartesian_to_spherical.sv =====
// Cartesian to spherical converter: top level, fully pipelined.
// Depends on c2s_pkg, c2s_isqrt and c2s_cordic.
//
// One point (x, y, z, signed Q16.16) is taken as a transaction at every
// rising clock edge where start is high; busy is tied low since the pipeline
// never stalls, so a point can enter in every cycle. Each point yields
// exactly one result, flagged by o_done for a single cycle, in input order;
// the receiver cannot hold it off. The path from input to result runs
// through squaring (2 stages), two 33-stage square roots in series
// (radius, then rho for the polar CORDIC), a 19-stage CORDIC
// (normalization plus 18 rotations) and the output register. The azimuth
// path passes through a delay line before its own 19-stage CORDIC, so both
// angles reach the output register together. The near_zero threshold
// should be written only while no transaction is in flight.
module cartesian_to_spherical (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  c2s_pkg::t_in_item       i_item,
    output logic                    o_done,
    output c2s_pkg::t_out_item      o_item,
    input  logic                    i_cfg_we,
    input  logic [16:0]             i_cfg_data
);
    import c2s_pkg::*;

    localparam logic signed [63:0] PiOut   = to_out(PiScaled);
    localparam logic signed [63:0] HalfPi  = to_out(PiScaled / 2);
    localparam logic signed [63:0] ThreePi = to_out(PiScaled + PiScaled / 2);
    localparam int SqDelay = 2;
    localparam int PathLen = SqDelay + SqrtSteps;
    localparam int PhiDelay = PathLen + SqrtSteps;

    logic [16:0] r_near_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_zero <= 17'd1;
        end else if (i_cfg_we) begin
            r_near_zero <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    // Squaring: stage 1 squares magnitudes, stage 2 adds them.
    logic        r_v1, r_v2;
    logic [63:0] r_x2, r_y2, r_z2;
    logic signed [31:0] r_zp1, r_zp2;
    logic [SqW-1:0] r_sxy, r_sall;

    logic [31:0] n_ax, n_ay, n_az;
    always_comb begin
        n_ax = i_item.x_coord[31] ? 32'(-i_item.x_coord) : 32'(i_item.x_coord);
        n_ay = i_item.y_coord[31] ? 32'(-i_item.y_coord) : 32'(i_item.y_coord);
        n_az = i_item.z_coord[31] ? 32'(-i_item.z_coord) : 32'(i_item.z_coord);
    end

    always_ff @(posedge i_clk) begin
        r_x2 <= n_ax * n_ax;
        r_y2 <= n_ay * n_ay;
        r_z2 <= n_az * n_az;
        r_zp1 <= i_item.z_coord;
        r_zp2 <= r_zp1;
        r_sxy  <= SqW'(r_x2) + SqW'(r_y2);
        r_sall <= SqW'(r_x2) + SqW'(r_y2) + SqW'(r_z2);
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
        end
    end

    // Radius root, carrying z and x^2+y^2 along.
    logic                 a_vld;
    logic [RootW-1:0]     a_root;
    logic [SqrtSideW-1:0] a_side;

    c2s_isqrt u_sqrt_r (
        .i_clk (i_clk), .i_rst_n(i_rst_n), .i_vld(r_v2), .i_val(r_sall),
        .i_side({r_zp2, r_sxy}), .o_vld(a_vld), .o_root(a_root), .o_side(a_side)
    );

    // Rho root, carrying z, radius and the small-radius flag.
    localparam int SideB = 32 + 32 + 1;
    logic                 b_vld;
    logic [RootW-1:0]     b_root;
    logic [SqrtSideW-1:0] b_side;
    logic                 n_small_r;

    assign n_small_r = (a_root < RootW'(r_near_zero)) || (a_root == '0);

    c2s_isqrt u_sqrt_rho (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(a_vld),
        .i_val(a_side[SqW-1:0]),
        .i_side({{(SqrtSideW-SideB){1'b0}}, a_side[SqrtSideW-1:SqW], a_root[31:0],
                 n_small_r}),
        .o_vld(b_vld), .o_root(b_root), .o_side(b_side)
    );

    // Polar CORDIC on (|z|, rho); z sign selects pi minus the angle.
    logic signed [31:0] n_zb;
    logic signed [33:0] n_pa;
    logic signed [63:0] th_ang;
    logic [SideB-1:0]   th_side;
    logic               th_vld;

    assign n_zb = b_side[SideB-1:33];
    assign n_pa = n_zb[31] ? -34'(n_zb) : 34'(n_zb);

    c2s_cordic u_cordic_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(b_vld), .i_a(n_pa),
        .i_b(34'(b_root)), .i_side(b_side[SideB-1:0]),
        .o_vld(th_vld), .o_ang(th_ang), .o_side(th_side)
    );

    // Azimuth: delay x, y and the threshold so that the CORDIC started at
    // the end of the delay line finishes together with the polar path.
    logic signed [31:0] r_dx [PhiDelay];
    logic signed [31:0] r_dy [PhiDelay];
    logic [16:0]        r_dnz[PhiDelay];
    logic               r_dv [PhiDelay];

    always_ff @(posedge i_clk) begin
        r_dx[0]  <= i_item.x_coord;
        r_dy[0]  <= i_item.y_coord;
        r_dnz[0] <= r_near_zero;
        for (int d = 1; d < PhiDelay; d++) begin
            r_dx[d]  <= r_dx[d-1];
            r_dy[d]  <= r_dy[d-1];
            r_dnz[d] <= r_dnz[d-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < PhiDelay; d++) begin
                r_dv[d] <= 1'b0;
            end
        end else begin
            r_dv[0] <= start;
            for (int d = 1; d < PhiDelay; d++) begin
                r_dv[d] <= r_dv[d-1];
            end
        end
    end

    logic signed [31:0] n_px, n_py;
    logic [31:0]        n_mx, n_my;
    t_phi_mode          n_pmode;
    logic signed [33:0] n_ca, n_cb;
    assign n_px = r_dx[PhiDelay-1];
    assign n_py = r_dy[PhiDelay-1];
    always_comb begin
        n_mx = n_px[31] ? 32'(-n_px) : 32'(n_px);
        n_my = n_py[31] ? 32'(-n_py) : 32'(n_py);
        if (n_mx < 32'(r_dnz[PhiDelay-1]) || n_px == 0) begin
            n_pmode = PhiFixed;
        end else if (!n_px[31]) begin
            n_pmode = PhiCordic;
        end else begin
            n_pmode = PhiPlusPi;
        end
        n_ca = n_px[31] ? -34'(n_px) : 34'(n_px);
        n_cb = n_px[31] ? -34'(n_py) : 34'(n_py);
    end

    logic [19:0] n_fix;
    always_comb begin
        if (n_my < 32'(r_dnz[PhiDelay-1])) begin
            n_fix = '0;
        end else if (n_py[31]) begin
            n_fix = ThreePi[19:0];
        end else begin
            n_fix = HalfPi[19:0];
        end
    end

    logic signed [63:0]     p_ang;
    logic [CordicSideW-1:0] p_side;
    logic                   p_vld;

    c2s_cordic u_cordic_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_dv[PhiDelay-1]), .i_a(n_ca),
        .i_b(n_cb), .i_side({{(CordicSideW-22){1'b0}}, n_pmode, n_fix}),
        .o_vld(p_vld), .o_ang(p_ang), .o_side(p_side)
    );

    // Output stage.
    logic signed [63:0] n_th, n_ph;
    logic [17:0]        n_theta;
    logic [19:0]        n_phi;
    always_comb begin
        n_th = to_out(th_side[SideB-1] ? PiScaled - th_ang : th_ang);
        if (th_side[0]) begin
            n_theta = '0;
        end else if (n_th < 0) begin
            n_theta = '0;
        end else if (n_th > PiOut) begin
            n_theta = PiOut[17:0];
        end else begin
            n_theta = n_th[17:0];
        end
        n_ph = to_out(p_side[21:20] == PhiPlusPi ? p_ang + PiScaled : p_ang);
        n_phi = (p_side[21:20] == PhiFixed) ? p_side[19:0] : n_ph[19:0];
    end

    t_out_item r_out;
    logic      r_done;
    always_ff @(posedge i_clk) begin
        r_out.radius      <= th_side[32:1];
        r_out.polar_angle <= n_theta;
        r_out.azimuth     <= n_phi;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= th_vld;
        end
    end
    assign o_done = r_done;
    assign o_item = r_out;

    a_no_busy: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised");
    a_phi_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        th_vld == p_vld)
        else $error("azimuth path out of step with polar path");
    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_item.polar_angle <= PiOut[17:0])
        else $error("theta out of range");

endmodule
